// ----- src/swlrl_pkg.sv -----
`default_nettype none

package swlrl_pkg;

    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd3;
    localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_EXPIRE,
        ST_DECIDE
    } t_state;

endpackage

`default_nettype wire

// ----- src/swlrl_req_if.sv -----
`default_nettype none

interface swlrl_req_if;
    logic                           valid;
    logic                           ready;
    logic [swlrl_pkg::SLOT_W-1:0]   user_slot;
    logic [swlrl_pkg::TIME_W-1:0]   now_time;

    modport source (output valid, output user_slot, output now_time, input ready);
    modport sink   (input valid, input user_slot, input now_time, output ready);
endinterface

`default_nettype wire

// ----- src/swlrl_rsp_if.sv -----
`default_nettype none

interface swlrl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, output allowed, input ready);
    modport sink   (input valid, input allowed, output ready);
endinterface

`default_nettype wire

// ----- src/sliding_window_log_rate_limiter.sv -----
`default_nettype none

// Channel   Direction  Port    Word
// ---------------------------------------------------------------
// request   in         i_req   user_slot[5:0], now_time[31:0]
// response  out        o_rsp   allowed
// config    in         APB     request_limit @0x0, window_length @0x4
//
// One request word is handled at a time: it is taken in idle, reads the user's
// ring state in meta, examines held stamps oldest first in expire through the
// single read port of the stamp memory, and answers in decide.
// After reset a clearing pass zeroes the per-user ring state of all NUM_USERS
// users; requests wait during it, configuration writes do not.
// A pending response word does not block the next request: only the decide
// state of an item waits for the output register to be free.
module sliding_window_log_rate_limiter #(
    parameter int NUM_USERS   = 64,
    parameter int MAX_ENTRIES = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    swlrl_req_if.sink                        i_req,
    swlrl_rsp_if.source                      o_rsp,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [swlrl_pkg::ADDR_W-1:0]      paddr,
    input  wire [swlrl_pkg::DATA_W-1:0]      pwdata,
    output logic [swlrl_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int PW    = CW + 1;
    localparam int MW    = EW + CW;
    localparam int DEPTH = NUM_USERS * MAX_ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SXW   = (UW > swlrl_pkg::SLOT_W) ? UW : swlrl_pkg::SLOT_W;
    localparam int TW    = swlrl_pkg::TIME_W;

    // Storage: per-user ring of stamps and per-user {oldest index, held count}.
    logic [TW-1:0] stamp_mem [DEPTH];
    logic [MW-1:0] meta_mem  [NUM_USERS];

    swlrl_pkg::t_state r_state, n_state;

    logic [UW-1:0]                     r_clr_idx, n_clr_idx;
    logic [swlrl_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic [TW-1:0]                     r_now, n_now;
    logic                              r_bad, n_bad;
    logic [EW-1:0]                     r_head, n_head;
    logic [CW-1:0]                     r_count, n_count;
    logic [swlrl_pkg::LIMIT_W-1:0]     r_limit;
    logic [TW-1:0]                     r_window;
    logic                              r_out_valid, n_out_valid;
    logic                              r_allowed, n_allowed;
    logic [TW-1:0]                     r_stamp_rd;
    logic [MW-1:0]                     r_meta_rd;

    logic                              cfg_wr;
    logic                              accept;
    logic                              out_free;
    logic [SXW-1:0]                    in_slot_x;
    logic [SXW-1:0]                    cur_slot_x;
    logic [UW-1:0]                     in_slot_idx;
    logic [UW-1:0]                     cur_slot_idx;
    logic [AW-1:0]                     slot_base;
    logic [EW-1:0]                     head_inc;
    logic [TW-1:0]                     age;
    logic                              expire;
    logic [CW-1:0]                     eff_limit;
    logic                              has_room;
    logic [PW-1:0]                     pos_sum;
    logic [EW-1:0]                     wr_pos;

    logic                              meta_we;
    logic [UW-1:0]                     meta_waddr;
    logic [MW-1:0]                     meta_wdata;
    logic                              stamp_we;
    logic [AW-1:0]                     stamp_waddr;
    logic [AW-1:0]                     stamp_raddr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            swlrl_pkg::REG_LIMIT:  prdata = swlrl_pkg::DATA_W'(r_limit);
            swlrl_pkg::REG_WINDOW: prdata = swlrl_pkg::DATA_W'(r_window);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= swlrl_pkg::LIMIT_RESET;
            r_window <= swlrl_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                swlrl_pkg::REG_LIMIT:  r_limit  <= pwdata[swlrl_pkg::LIMIT_W-1:0];
                swlrl_pkg::REG_WINDOW: r_window <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath helpers ----------------
    assign accept       = i_req.valid && i_req.ready;
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign in_slot_x    = SXW'(i_req.user_slot);
    assign cur_slot_x   = SXW'(r_slot);
    assign in_slot_idx  = in_slot_x[UW-1:0];
    assign cur_slot_idx = cur_slot_x[UW-1:0];
    assign slot_base    = AW'(cur_slot_idx) * AW'(MAX_ENTRIES);

    assign head_inc = (r_head == EW'(MAX_ENTRIES - 1)) ? '0 : r_head + EW'(1);
    // Wrapping age; a stamp expires once its age reaches the window.
    assign age      = r_now - r_stamp_rd;
    assign expire   = (age >= r_window);

    assign eff_limit = (32'(r_limit) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(r_limit);
    assign has_room  = !r_bad && (r_count < eff_limit);

    // head is below MAX_ENTRIES and count at most MAX_ENTRIES, so one subtract wraps.
    assign pos_sum = PW'(r_head) + PW'(r_count);
    always_comb begin
        if (pos_sum >= PW'(MAX_ENTRIES)) begin
            wr_pos = EW'(pos_sum - PW'(MAX_ENTRIES));
        end else begin
            wr_pos = EW'(pos_sum);
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            swlrl_pkg::ST_CLEAR: begin
                if (r_clr_idx == UW'(NUM_USERS - 1)) begin
                    n_state = swlrl_pkg::ST_IDLE;
                end
            end
            swlrl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (32'(i_req.user_slot) >= NUM_USERS) begin
                        n_state = swlrl_pkg::ST_DECIDE;
                    end else begin
                        n_state = swlrl_pkg::ST_META;
                    end
                end
            end
            swlrl_pkg::ST_META: begin
                if (r_meta_rd[CW-1:0] != '0) begin
                    n_state = swlrl_pkg::ST_EXPIRE;
                end else begin
                    n_state = swlrl_pkg::ST_DECIDE;
                end
            end
            swlrl_pkg::ST_EXPIRE: begin
                if (!expire || (r_count == CW'(1))) begin
                    n_state = swlrl_pkg::ST_DECIDE;
                end
            end
            swlrl_pkg::ST_DECIDE: begin
                if (out_free) begin
                    n_state = swlrl_pkg::ST_IDLE;
                end
            end
            default: n_state = swlrl_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        i_req.ready = 1'b0;
        n_clr_idx   = r_clr_idx;
        n_slot      = r_slot;
        n_now       = r_now;
        n_bad       = r_bad;
        n_head      = r_head;
        n_count     = r_count;
        n_allowed   = r_allowed;
        n_out_valid = r_out_valid && !o_rsp.ready;
        meta_we     = 1'b0;
        meta_waddr  = cur_slot_idx;
        meta_wdata  = {r_head, r_count};
        stamp_we    = 1'b0;
        stamp_waddr = slot_base + AW'(wr_pos);

        case (r_state)
            swlrl_pkg::ST_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr_idx;
                meta_wdata = '0;
                n_clr_idx  = r_clr_idx + UW'(1);
            end
            swlrl_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_slot = i_req.user_slot;
                    n_now  = i_req.now_time;
                    n_bad  = (32'(i_req.user_slot) >= NUM_USERS);
                end
            end
            swlrl_pkg::ST_META: begin
                n_head  = r_meta_rd[MW-1:CW];
                n_count = r_meta_rd[CW-1:0];
            end
            swlrl_pkg::ST_EXPIRE: begin
                if (expire) begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            swlrl_pkg::ST_DECIDE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_allowed   = has_room;
                    stamp_we    = has_room;
                    meta_we     = !r_bad;
                    meta_wdata  = {r_head, has_room ? r_count + CW'(1) : r_count};
                end
            end
            default: ;
        endcase
    end

    // The stamp memory always reads the entry the next cycle will examine.
    assign stamp_raddr = slot_base + AW'(n_head);

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.allowed = r_allowed;

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_rd <= meta_mem[in_slot_idx];
    end

    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            stamp_mem[stamp_waddr] <= r_now;
        end
        r_stamp_rd <= stamp_mem[stamp_raddr];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swlrl_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
            r_bad       <= n_bad;
            r_head      <= n_head;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_now     <= n_now;
        r_allowed <= n_allowed;
    end

endmodule

`default_nettype wire

// ----- verif/tb_sliding_window_log_rate_limiter.sv -----
module tb_sliding_window_log_rate_limiter;

    localparam int NUM_USERS    = 64;
    localparam int MAX_ENTRIES  = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_ERRORS = 10;

    typedef enum {
        PACE_FREE,
        PACE_RANDOM,
        PACE_PERIODIC,
        PACE_SLOW
    } t_pace;

    typedef struct packed {
        logic [swlrl_pkg::SLOT_W-1:0] user_slot;
        logic [swlrl_pkg::TIME_W-1:0] now_time;
        logic                         allowed;
    } t_verdict;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [swlrl_pkg::ADDR_W-1:0] paddr;
    logic [swlrl_pkg::DATA_W-1:0] pwdata;
    logic [swlrl_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    swlrl_req_if req_if ();
    swlrl_rsp_if rsp_if ();

    sliding_window_log_rate_limiter #(
        .NUM_USERS   (NUM_USERS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the per-user stamp rings and of the two registers.
    logic [swlrl_pkg::TIME_W-1:0]  log_stamp [NUM_USERS][MAX_ENTRIES];
    int                            log_head  [NUM_USERS];
    int                            log_fill  [NUM_USERS];
    logic [swlrl_pkg::LIMIT_W-1:0] cur_limit;
    logic [swlrl_pkg::TIME_W-1:0]  cur_window;
    logic [swlrl_pkg::TIME_W-1:0]  user_clock [NUM_USERS];

    t_verdict expected_verdicts [$];
    int       verdict_errors = 0;
    int       cycle_count = 0;

    t_pace verdict_pace;
    int    hold_asks;
    int    hold_seen = 0;
    int    hold_left = 0;
    int    pace_tick = 0;
    bit    gaps_on;
    int    burst_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic predict_verdict(input logic [swlrl_pkg::SLOT_W-1:0] slot,
                                             input logic [swlrl_pkg::TIME_W-1:0] now);
        int                           head;
        int                           fill;
        int                           cap;
        logic [swlrl_pkg::TIME_W-1:0] age;
        logic                         grant;
        if (slot >= NUM_USERS)
            return 1'b0;
        head = log_head[slot];
        fill = log_fill[slot];
        // Drop the oldest stamps whose wrapped age has reached the window.
        while (fill > 0) begin
            age = now - log_stamp[slot][head];
            if (age < cur_window)
                break;
            head = (head + 1) % MAX_ENTRIES;
            fill--;
        end
        cap = (cur_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_limit);
        grant = (fill < cap);
        if (grant) begin
            log_stamp[slot][(head + fill) % MAX_ENTRIES] = now;
            fill++;
        end
        log_head[slot] = head;
        log_fill[slot] = fill;
        return grant;
    endfunction

    // Checks each response word against the oldest prediction, then paces ready.
    always @(posedge i_clk) begin : verdict_monitor
        t_verdict want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_verdicts.size() == 0) begin
                verdict_errors++;
                if (verdict_errors <= SHOWN_ERRORS)
                    $display("unexpected response word: allowed=%0b", rsp_if.allowed);
            end else begin
                want = expected_verdicts.pop_front();
                if (rsp_if.allowed !== want.allowed) begin
                    verdict_errors++;
                    if (verdict_errors <= SHOWN_ERRORS)
                        $display("slot %0d time %08h: allowed expected %0b, got %0b",
                                 want.user_slot, want.now_time, want.allowed,
                                 rsp_if.allowed);
                end
            end
        end
        pace_tick++;
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            case (verdict_pace)
                PACE_FREE:     rsp_if.ready <= 1'b1;
                PACE_RANDOM:   rsp_if.ready <= ($urandom_range(3) != 0);
                PACE_PERIODIC: rsp_if.ready <= ((pace_tick % 7) < 4);
                default:       rsp_if.ready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    task automatic issue_request(input logic [swlrl_pkg::SLOT_W-1:0] slot,
                                 input logic [swlrl_pkg::TIME_W-1:0] now);
        t_verdict v;
        req_if.valid     <= 1'b1;
        req_if.user_slot <= slot;
        req_if.now_time  <= now;
        do @(posedge i_clk); while (!req_if.ready);
        v.user_slot = slot;
        v.now_time  = now;
        v.allowed   = predict_verdict(slot, now);
        expected_verdicts.push_back(v);
        user_clock[slot] = now;
    endtask

    // Lowers valid and waits until every predicted response word has come back.
    task automatic await_verdicts();
        req_if.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel,
                                  input logic [swlrl_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == swlrl_pkg::REG_LIMIT)
            cur_limit = value[swlrl_pkg::LIMIT_W-1:0];
        else
            cur_window = value[swlrl_pkg::TIME_W-1:0];
    endtask

    task automatic pace_requests();
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
                burst_left = $urandom_range(24, 1);
            end
        end
    endtask

    // Steps are often small, with a share landing right around the window edge.
    function automatic logic [swlrl_pkg::TIME_W-1:0] time_step();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(2);
            4:          return cur_window - 1;
            5:          return cur_window;
            6:          return cur_window + 1;
            7:          return $urandom_range(cur_window);
            8:          return cur_window >> $urandom_range(4, 1);
            default:    return $urandom;
        endcase
    endfunction

    task automatic run_traffic(input int count, input int span);
        logic [swlrl_pkg::SLOT_W-1:0] slot;
        logic [swlrl_pkg::TIME_W-1:0] stamp;
        int                           base;
        base = $urandom_range(NUM_USERS - 1);
        for (int n = 0; n < count; n++) begin
            slot = swlrl_pkg::SLOT_W'((base + $urandom_range(span - 1)) % NUM_USERS);
            if ($urandom_range(19) == 0)
                stamp = $urandom;
            else
                stamp = user_clock[slot] + time_step();
            issue_request(slot, stamp);
            pace_requests();
        end
    endtask

    task automatic test_reset_settings();
        repeat (4) issue_request(6'd0, 32'd100);
        issue_request(6'd0, 32'd105);
        await_verdicts();
    endtask

    task automatic test_zero_window_and_limit();
        write_register(swlrl_pkg::REG_WINDOW, 32'd0);
        issue_request(6'd1, 32'd7);
        issue_request(6'd1, 32'd7);
        await_verdicts();
        write_register(swlrl_pkg::REG_LIMIT, 32'd0);
        issue_request(6'd1, 32'd7);
        await_verdicts();
    endtask

    task automatic test_limit_above_capacity();
        write_register(swlrl_pkg::REG_LIMIT, 32'd31);
        write_register(swlrl_pkg::REG_WINDOW, 32'hFFFF_FFFF);
        repeat (MAX_ENTRIES + 1) issue_request(6'd63, 32'hFFFF_FFFF);
        await_verdicts();
    endtask

    task automatic test_time_wrap();
        write_register(swlrl_pkg::REG_LIMIT, 32'd2);
        write_register(swlrl_pkg::REG_WINDOW, 32'd5);
        issue_request(6'd3, 32'hFFFF_FFFE);
        issue_request(6'd3, 32'hFFFF_FFFF);
        issue_request(6'd3, 32'h0000_0003);
        await_verdicts();
    endtask

    task automatic test_limit_window_sweep();
        logic [swlrl_pkg::DATA_W-1:0] lim;
        logic [swlrl_pkg::DATA_W-1:0] win;
        int                           span;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin lim = 3;  win = 5;               span = 4;  end
                1:       begin lim = 0;  win = 7;               span = 4;  end
                2:       begin lim = 16; win = 40;              span = 2;  end
                3:       begin lim = 31; win = 32'hFFFF_FFFF;   span = 3;  end
                4:       begin lim = 1;  win = 0;               span = 8;  end
                5:       begin lim = 17; win = 1;               span = 2;  end
                6:       begin lim = $urandom_range(31); win = $urandom; span = 64; end
                default: begin
                    lim  = $urandom_range(31);
                    win  = $urandom_range(30);
                    span = 6;
                end
            endcase
            await_verdicts();
            write_register(swlrl_pkg::REG_LIMIT, lim);
            write_register(swlrl_pkg::REG_WINDOW, win);
            gaps_on      = ((p % 3) != 2);
            burst_left   = 1;
            verdict_pace <= t_pace'(p % 4);
            run_traffic(150, span);
        end
    endtask

    // The receiver refuses words for a long stretch while requests keep coming,
    // so the output register stays full and the request channel backs up.
    task automatic test_response_backpressure();
        await_verdicts();
        write_register(swlrl_pkg::REG_LIMIT, 32'd4);
        write_register(swlrl_pkg::REG_WINDOW, 32'd10);
        gaps_on      = 1'b0;
        verdict_pace <= PACE_RANDOM;
        hold_asks    <= hold_asks + 1;
        run_traffic(130, 5);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.user_slot = '0;
        req_if.now_time  = '0;
        rsp_if.ready     = 1'b0;
        hold_asks        = 0;
        verdict_pace     = PACE_RANDOM;
        gaps_on          = 1'b0;
        burst_left       = 1;
        cur_limit        = swlrl_pkg::LIMIT_RESET;
        cur_window       = swlrl_pkg::WINDOW_RESET;
        for (int u = 0; u < NUM_USERS; u++) begin
            log_head[u]   = 0;
            log_fill[u]   = 0;
            user_clock[u] = '0;
            for (int e = 0; e < MAX_ENTRIES; e++)
                log_stamp[u][e] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_zero_window_and_limit();
        test_limit_above_capacity();
        test_time_wrap();
        test_limit_window_sweep();
        test_response_backpressure();

        await_verdicts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdict_errors == 0 && expected_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
src/swlrl_pkg.sv
src/swlrl_req_if.sv
src/swlrl_rsp_if.sv
src/sliding_window_log_rate_limiter.sv
verif/tb_sliding_window_log_rate_limiter.sv
